// ===== rtl/lbrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbrs_pkg
// Shared types and constants of the bilinear remap sampler.
// ----------------------------------------------------------------------------
package lbrs_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int PIX_W     = 8;
    localparam int FRAC_W    = 16;
    localparam int COORD_W   = 9;
    localparam int WADDR_W   = 18;
    localparam int DIM_W     = 10;
    localparam int ACC_W     = 32;
    localparam int STAGE1_SH = 8;

    localparam int DIM_MAX = (1 << DIM_W) - 1;

    localparam logic [DIM_W-1:0]  MIN_DIM       = 10'd4;
    localparam logic [DIM_W-1:0]  DIM_RESET     = 10'd512;
    localparam logic [FRAC_W-1:0] FRAC_ONE      = 16'hFFFF;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_RD0,
        S_RD1,
        S_LOAD,
        S_R0,
        S_R1,
        S_L0,
        S_L1,
        S_H0,
        S_H1,
        S_DONE
    } state_t;

    typedef struct packed {
        logic en;
        logic clr;
    } mac_ctl_t;

endpackage

// ===== rtl/lut_bilinear_remap_sampler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_bilinear_remap_sampler_core
// Frame store with 2x2 bilinear sampling from remap table entries.
// Sequence: a sample item steps through address, read, load, MAC and done states.
// Throughput: one write item per cycle while idle; no item is taken while a
//   sample runs its two two-port frame store reads and six shared MAC passes.
// Reset: src_width and src_height return to 512; frame contents are
//   undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module lut_bilinear_remap_sampler_core #(
    parameter int MAX_WIDTH  = lbrs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbrs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lbrs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lbrs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lbrs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [lbrs_pkg::WADDR_W-1:0]    write_addr,
    input  logic [lbrs_pkg::PIX_W-1:0]      write_value,
    input  logic [lbrs_pkg::COORD_W-1:0]    sample_col,
    input  logic [lbrs_pkg::COORD_W-1:0]    sample_row,
    input  logic [lbrs_pkg::FRAC_W-1:0]     row_frac,
    input  logic [lbrs_pkg::FRAC_W-1:0]     col_frac,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lbrs_pkg::PIX_W-1:0]      out_pixel,
    output logic                            range_error
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int DW  = lbrs_pkg::DIM_W;
    localparam int PW  = 2 * DW + 1;
    localparam int FW  = lbrs_pkg::FRAC_W;
    localparam int XW  = lbrs_pkg::PIX_W;
    localparam int CW  = lbrs_pkg::ACC_W;
    localparam int DWR = lbrs_pkg::CFG_DATA_W;

    localparam logic [DW-1:0] W_CLIP =
        (MAX_WIDTH > lbrs_pkg::DIM_MAX) ? DW'(lbrs_pkg::DIM_MAX) : DW'(MAX_WIDTH);
    localparam logic [DW-1:0] H_CLIP =
        (MAX_HEIGHT > lbrs_pkg::DIM_MAX) ? DW'(lbrs_pkg::DIM_MAX) : DW'(MAX_HEIGHT);

    // configuration
    logic [DW-1:0] src_width_reg;
    logic [DW-1:0] src_height_reg;
    logic          cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= lbrs_pkg::DIM_RESET;
            src_height_reg <= lbrs_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                lbrs_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[DW-1:0];
                lbrs_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lbrs_pkg::REG_SRC_WIDTH:  prdata = DWR'(src_width_reg);
            lbrs_pkg::REG_SRC_HEIGHT: prdata = DWR'(src_height_reg);
            default:                  prdata = '0;
        endcase
    end

    // effective dimensions and neighbourhood clamp
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [DW-1:0] col_lim;
    logic [DW-1:0] row_lim;
    logic [DW-1:0] col_ext;
    logic [DW-1:0] row_ext;
    logic          col_over;
    logic          row_over;

    always_comb
    begin
        if (src_width_reg < lbrs_pkg::MIN_DIM)
            w_eff = lbrs_pkg::MIN_DIM;
        else if (src_width_reg > W_CLIP)
            w_eff = W_CLIP;
        else
            w_eff = src_width_reg;

        if (src_height_reg < lbrs_pkg::MIN_DIM)
            h_eff = lbrs_pkg::MIN_DIM;
        else if (src_height_reg > H_CLIP)
            h_eff = H_CLIP;
        else
            h_eff = src_height_reg;

        col_lim  = w_eff - DW'(2);
        row_lim  = h_eff - DW'(2);
        col_ext  = DW'(sample_col);
        row_ext  = DW'(sample_row);
        col_over = col_ext > col_lim;
        row_over = row_ext > row_lim;
    end

    // control
    lbrs_pkg::state_t   state_reg;
    lbrs_pkg::state_t   state_next;
    lbrs_pkg::mac_ctl_t mac_ctl;
    logic               accept;
    logic               wr_in_range;
    logic               mem_we;
    logic               out_load;
    logic               out_valid_reg;
    logic               out_valid_next;

    assign accept      = in_valid && !in_stall;
    assign wr_in_range = 32'(write_addr) < STORE_DEPTH;
    assign mem_we      = accept && (opcode == lbrs_pkg::OP_WRITE) && wr_in_range;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbrs_pkg::S_IDLE:
                if (accept && (opcode == lbrs_pkg::OP_SAMPLE))
                    state_next = lbrs_pkg::S_ADDR;
            lbrs_pkg::S_ADDR: state_next = lbrs_pkg::S_RD0;
            lbrs_pkg::S_RD0:  state_next = lbrs_pkg::S_RD1;
            lbrs_pkg::S_RD1:  state_next = lbrs_pkg::S_LOAD;
            lbrs_pkg::S_LOAD: state_next = lbrs_pkg::S_R0;
            lbrs_pkg::S_R0:   state_next = lbrs_pkg::S_R1;
            lbrs_pkg::S_R1:   state_next = lbrs_pkg::S_L0;
            lbrs_pkg::S_L0:   state_next = lbrs_pkg::S_L1;
            lbrs_pkg::S_L1:   state_next = lbrs_pkg::S_H0;
            lbrs_pkg::S_H0:   state_next = lbrs_pkg::S_H1;
            lbrs_pkg::S_H1:   state_next = lbrs_pkg::S_DONE;
            lbrs_pkg::S_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = lbrs_pkg::S_IDLE;
            default: state_next = lbrs_pkg::S_IDLE;
        endcase
    end

    // datapath registers
    logic [DW-1:0] col_reg;
    logic [DW-1:0] row_reg;
    logic          err_reg;
    logic [FW-1:0] a_reg;
    logic [FW-1:0] na_reg;
    logic [FW-1:0] b_reg;
    logic [FW-1:0] nb_reg;
    logic [AW-1:0] base_reg;
    logic [XW-1:0] g00_reg;
    logic [XW-1:0] g01_reg;
    logic [XW-1:0] g10_reg;
    logic [XW-1:0] g11_reg;
    logic [FW-1:0] right_reg;
    logic [FW-1:0] left_reg;
    logic [XW-1:0] out_pixel_reg;
    logic          range_error_reg;

    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic [XW-1:0] rdata0;
    logic [XW-1:0] rdata1;
    logic [FW-1:0] mac_x;
    logic [FW-1:0] mac_y;
    logic [CW-1:0] acc;
    logic [PW-1:0] base_sum;
    logic [AW-1:0] w_aw;

    always_comb
    begin
        in_stall = (state_reg != lbrs_pkg::S_IDLE);
        out_load = (state_reg == lbrs_pkg::S_DONE) && (!out_valid_reg || !out_stall);
        mac_ctl  = '0;
        mac_x    = a_reg;
        mac_y    = FW'(g11_reg);
        w_aw     = AW'(w_eff);
        base_sum = PW'(row_reg) * PW'(w_eff) + PW'(col_reg);
        rd_addr0 = base_reg;
        rd_addr1 = base_reg;
        unique case (state_reg)
            lbrs_pkg::S_RD0:
            begin
                rd_addr1 = base_reg + AW'(1);
            end
            lbrs_pkg::S_RD1:
            begin
                rd_addr0 = base_reg + w_aw;
                rd_addr1 = base_reg + w_aw + AW'(1);
            end
            lbrs_pkg::S_R0:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
            end
            lbrs_pkg::S_R1:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b0};
                mac_x   = na_reg;
                mac_y   = FW'(g01_reg);
            end
            lbrs_pkg::S_L0:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
                mac_y   = FW'(g10_reg);
            end
            lbrs_pkg::S_L1:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b0};
                mac_x   = na_reg;
                mac_y   = FW'(g00_reg);
            end
            lbrs_pkg::S_H0:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b1};
                mac_x   = b_reg;
                mac_y   = right_reg;
            end
            lbrs_pkg::S_H1:
            begin
                mac_ctl = '{en: 1'b1, clr: 1'b0};
                mac_x   = nb_reg;
                mac_y   = left_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbrs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == lbrs_pkg::OP_SAMPLE))
        begin
            col_reg <= col_over ? col_lim : col_ext;
            row_reg <= row_over ? row_lim : row_ext;
            err_reg <= col_over || row_over;
            a_reg   <= row_frac;
            na_reg  <= lbrs_pkg::FRAC_ONE - row_frac;
            b_reg   <= col_frac;
            nb_reg  <= lbrs_pkg::FRAC_ONE - col_frac;
        end
        if (state_reg == lbrs_pkg::S_ADDR)
            base_reg <= AW'(base_sum);
        if (state_reg == lbrs_pkg::S_RD1)
        begin
            g00_reg <= rdata0;
            g01_reg <= rdata1;
        end
        if (state_reg == lbrs_pkg::S_LOAD)
        begin
            g10_reg <= rdata0;
            g11_reg <= rdata1;
        end
        if (state_reg == lbrs_pkg::S_L0)
            right_reg <= acc[lbrs_pkg::STAGE1_SH +: FW];
        if (state_reg == lbrs_pkg::S_H0)
            left_reg <= acc[lbrs_pkg::STAGE1_SH +: FW];
        if (out_load)
        begin
            out_pixel_reg   <= acc[CW-1 -: XW];
            range_error_reg <= err_reg;
        end
    end

    lbrs_frame_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (AW'(write_addr)),
        .wdata  (write_value),
        .raddr0 (rd_addr0),
        .raddr1 (rd_addr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    lbrs_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .x   (mac_x),
        .y   (mac_y),
        .acc (acc)
    );

    assign out_valid   = out_valid_reg;
    assign out_pixel   = out_pixel_reg;
    assign range_error = range_error_reg;

    a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == lbrs_pkg::S_IDLE))
        else $error("frame store written while a sample is in flight");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == lbrs_pkg::OP_SAMPLE)) |=> (state_reg == lbrs_pkg::S_ADDR))
        else $error("accepted sample item did not start");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lbrs_pkg::S_RD1) |-> (32'(rd_addr1) < STORE_DEPTH))
        else $error("neighbour read past the frame store");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == lbrs_pkg::S_DONE))
        else $error("result item raised outside the final step");

endmodule

// ===== rtl/lbrs_frame_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbrs_frame_mem
// Source frame store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lbrs_frame_mem #(
    parameter int DEPTH = lbrs_pkg::DEF_MAX_WIDTH * lbrs_pkg::DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [lbrs_pkg::PIX_W-1:0] wdata,
    input  logic [AW-1:0]              raddr0,
    input  logic [AW-1:0]              raddr1,
    output logic [lbrs_pkg::PIX_W-1:0] rdata0,
    output logic [lbrs_pkg::PIX_W-1:0] rdata1
);

    logic [lbrs_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== rtl/lbrs_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbrs_mac
// Shared 16x16 multiply-accumulate unit for both interpolation passes.
// ----------------------------------------------------------------------------
module lbrs_mac (
    input  logic                        clk,
    input  lbrs_pkg::mac_ctl_t          ctl,
    input  logic [lbrs_pkg::FRAC_W-1:0] x,
    input  logic [lbrs_pkg::FRAC_W-1:0] y,
    output logic [lbrs_pkg::ACC_W-1:0]  acc
);

    localparam int AW = lbrs_pkg::ACC_W;

    logic [AW-1:0] acc_reg;
    logic [AW-1:0] acc_next;
    logic [AW-1:0] prod;

    always_comb
    begin
        prod     = AW'(x) * AW'(y);
        acc_next = (ctl.clr ? '0 : acc_reg) + prod;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
